@@ hdl/lstk_pkg.sv @@
package lstk_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 5;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_SRCH = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // which result the datapath should form
  typedef enum logic [2:0] {
    RES_OK,
    RES_EMPTY,
    RES_FULL,
    RES_NOTFOUND,
    RES_POPPED,
    RES_FOUND
  } res_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_DONE,
    S_SEARCH
  } state_t;

  typedef struct packed {
    logic      latch;
    logic      push;
    logic      pop;
    logic      srch_init;
    logic      srch_step;
    logic      res_en;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    empty;
    logic    full;
    logic    match;
    logic    last;
  } sts_t;

endpackage

@@ hdl/lstk_ctrl.sv @@
module lstk_ctrl
  import lstk_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_kind = RES_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_PUSH: begin
            cmd.res_en   = 1'b1;
            cmd.res_kind = sts.full ? RES_FULL : RES_OK;
            cmd.push     = !sts.full;
            state_nxt    = S_IDLE;
          end
          OP_POP: begin
            if (sts.empty) begin
              cmd.res_en   = 1'b1;
              cmd.res_kind = RES_EMPTY;
              state_nxt    = S_IDLE;
            end else begin
              cmd.pop   = 1'b1;
              state_nxt = S_POP_DONE;
            end
          end
          OP_SRCH: begin
            if (sts.empty) begin
              cmd.res_en   = 1'b1;
              cmd.res_kind = RES_EMPTY;
              state_nxt    = S_IDLE;
            end else begin
              cmd.srch_init = 1'b1;
              state_nxt     = S_SEARCH;
            end
          end
          default: begin
            cmd.res_en   = 1'b1;
            cmd.res_kind = RES_OK;
            state_nxt    = S_IDLE;
          end
        endcase
      end
      S_POP_DONE: begin
        cmd.res_en   = 1'b1;
        cmd.res_kind = RES_POPPED;
        state_nxt    = S_IDLE;
      end
      S_SEARCH: begin
        if (sts.match) begin
          cmd.res_en   = 1'b1;
          cmd.res_kind = RES_FOUND;
          state_nxt    = S_IDLE;
        end else if (sts.last) begin
          cmd.res_en   = 1'b1;
          cmd.res_kind = RES_NOTFOUND;
          state_nxt    = S_IDLE;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/lstk_dpath.sv @@
module lstk_dpath
  import lstk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  input  logic [1:0]               in_opcode,
  input  logic signed [WORD_W-1:0] in_value,
  output sts_t                     sts,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic signed [WORD_W-1:0] out_popped_value,
  output logic [POS_W-1:0]         out_position
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem [DEPTH];

  opcode_t           op_r;
  logic [WORD_W-1:0] value_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [AW-1:0]     ptr_r;
  logic [CW-1:0]     pos_r;
  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data_r;

  logic              res_valid_r;
  status_t           res_status_r;
  logic [WORD_W-1:0] res_popped_r;
  logic [POS_W-1:0]  res_pos_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= opcode_t'(in_opcode);
      value_r <= in_value;
    end
  end

  // entry just below count; wraps when empty but the data is then unused
  assign top_addr = AW'(count_r - CW'(1));
  assign rd_addr  = cmd.srch_step ? (ptr_r - AW'(1)) : top_addr;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count_r[AW-1:0]] <= value_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // ptr_r addresses the entry whose data is in rd_data_r during the walk
  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      ptr_r <= top_addr;
      pos_r <= CW'(1);
    end else if (cmd.srch_step) begin
      ptr_r <= ptr_r - AW'(1);
      pos_r <= pos_r + CW'(1);
    end
  end

  assign sts.op    = op_r;
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(DEPTH));
  assign sts.match = (rd_data_r == value_r);
  assign sts.last  = (pos_r == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= cmd.res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      res_status_r <= ST_OK;
      res_popped_r <= '0;
      res_pos_r    <= '0;
      case (cmd.res_kind)
        RES_EMPTY:    res_status_r <= ST_EMPTY;
        RES_FULL:     res_status_r <= ST_FULL;
        RES_NOTFOUND: res_status_r <= ST_NOTFOUND;
        RES_POPPED:   res_popped_r <= rd_data_r;
        RES_FOUND:    res_pos_r    <= POS_W'(pos_r);
        default:      res_status_r <= ST_OK;
      endcase
    end
  end

  assign out_strobe       = res_valid_r;
  assign out_status       = res_status_r;
  assign out_popped_value = res_popped_r;
  assign out_position     = res_pos_r;

endmodule

@@ hdl/lifo_stack_with_search.sv @@
// bounded lifo stack with push, pop and top-down search, one result per item
// push, unused opcode and pop or search on an empty stack are answered in S_EXEC;
// a pop passes S_EXEC then S_POP_DONE; a search walks in S_SEARCH from the top
// to the matching position or, on a miss, to the count; the walk reads one entry a cycle
// a new item may start in the cycle its result is strobed
// synchronous active-low reset empties the stack; results cannot be stalled
module lifo_stack_with_search
  import lstk_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_opcode,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic signed [WORD_W-1:0] out_popped_value,
  output logic [POS_W-1:0]         out_position
);

  cmd_t cmd;
  sts_t sts;

  lstk_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lstk_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .sts              (sts),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_position     (out_position)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobed while still working");

  a_fields_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_position != '0 || out_popped_value != '0))
      |-> (out_status == ST_OK))
    else $error("position or popped value set on a failing result");

endmodule

@@ test/lifo_stack_with_search_tb.sv @@
`timescale 1ns / 1ps

module lifo_stack_with_search_tb;
  import lstk_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int NUM_DIR     = 26;
  localparam int NUM_RAND    = 410;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] popped;
    logic [POS_W-1:0]  pos;
  } stack_result_t;

  typedef struct packed {
    opcode_t           op;
    logic [WORD_W-1:0] value;
    logic              typed;
    stack_result_t     res;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_opcode;
  logic signed [WORD_W-1:0] in_value;
  logic                     out_strobe;
  logic [1:0]               out_status;
  logic signed [WORD_W-1:0] out_popped_value;
  logic [POS_W-1:0]         out_position;

  lifo_stack_with_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_position     (out_position)
  );

  // own image of the stack, bottom entry at index 0
  logic [WORD_W-1:0] stack_img [STACK_DEPTH];
  int                depth_used;
  stack_result_t     pending_results [$];
  dir_row_t          dir_tab [NUM_DIR];

  int errors;
  int n_push, n_over, n_pop, n_under, n_srch, n_found, n_miss, n_none, n_deep;
  bit no_idle;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic stack_result_t stack_apply(opcode_t op, logic [WORD_W-1:0] v);
    stack_result_t r;
    r = '{ST_OK, '0, '0};
    case (op)
      OP_PUSH: begin
        if (depth_used >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_img[depth_used] = v;
          depth_used++;
        end
      end
      OP_POP: begin
        if (depth_used == 0) begin
          r.status = ST_EMPTY;
        end else begin
          depth_used--;
          r.popped = stack_img[depth_used];
        end
      end
      OP_SRCH: begin
        if (depth_used == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          // walk from the top, first match wins
          for (int p = 1; p <= depth_used; p++) begin
            if (stack_img[depth_used - p] == v) begin
              r.status = ST_OK;
              r.pos    = p[POS_W-1:0];
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // presents one item, waits for it to be taken and files its expected result
  task automatic send_item(opcode_t op, logic [WORD_W-1:0] v, bit typed,
                           stack_result_t typed_res);
    stack_result_t r;
    int            gap;
    if (!no_idle && $urandom_range(0, 99) < 24) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    in_opcode <= op;
    in_value  <= v;
    do @(posedge clk); while (busy);
    r = stack_apply(op, v);
    case (op)
      OP_PUSH: begin n_push++; if (r.status == ST_FULL) n_over++; end
      OP_POP:  begin n_pop++;  if (r.status == ST_EMPTY) n_under++; end
      OP_SRCH: begin
        n_srch++;
        if (r.status == ST_OK) n_found++;
        if (r.status == ST_NOTFOUND) n_miss++;
        if (r.pos >= POS_W'(STACK_DEPTH - 2)) n_deep++;
      end
      default: n_none++;
    endcase
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  stack_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with no item outstanding: status %0d", out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_popped_value !== want.popped ||
            out_position !== want.pos) begin
          note_mismatch($sformatf(
            "mismatch: status %0d/%0d popped %h/%h position %0d/%0d (expected/actual)",
            want.status, out_status, want.popped, out_popped_value,
            want.pos, out_position));
        end
      end
    end
  end

  // small pool so that duplicates and hits come up often
  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return WORD_W'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    opcode_t           op;
    logic [WORD_W-1:0] v;
    int                rand_done;
    int                mode;
    int                mode_left;
    int                roll;
    int                push_pct;

    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_opcode = OP_NONE;
    in_value  = '0;
    errors    = 0;
    depth_used = 0;
    no_idle   = 1'b0;
    {n_push, n_over, n_pop, n_under, n_srch, n_found, n_miss, n_none, n_deep} = '0;

    dir_tab = '{
      '{OP_POP,  32'h0000_0000, 1'b1, '{ST_EMPTY,    32'h0000_0000, 5'd0}},
      '{OP_SRCH, 32'h0000_0000, 1'b1, '{ST_EMPTY,    32'h0000_0000, 5'd0}},
      '{OP_NONE, 32'hFFFF_FFFF, 1'b1, '{ST_OK,       32'h0000_0000, 5'd0}},
      '{OP_PUSH, 32'h7FFF_FFFF, 1'b1, '{ST_OK,       32'h0000_0000, 5'd0}},
      '{OP_PUSH, 32'h0000_0000, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h0000_0001, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'hFFFF_FFFF, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'hAAAA_AAAA, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h5555_5555, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h0000_0005, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h0000_0005, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h0001_0000, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h7FFF_FFFE, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h8000_0001, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h0000_0064, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h0000_00C8, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h0000_0001, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h0000_012C, 1'b0, '{ST_OK, '0, '0}},
      '{OP_PUSH, 32'h8000_0000, 1'b1, '{ST_OK,       32'h0000_0000, 5'd0}},
      '{OP_PUSH, 32'h0000_0000, 1'b1, '{ST_FULL,     32'h0000_0000, 5'd0}},
      '{OP_SRCH, 32'h7FFF_FFFF, 1'b1, '{ST_OK,       32'h0000_0000, 5'd16}},
      '{OP_SRCH, 32'h8000_0000, 1'b1, '{ST_OK,       32'h0000_0000, 5'd1}},
      '{OP_SRCH, 32'h0000_0001, 1'b0, '{ST_OK, '0, '0}},
      '{OP_SRCH, 32'h1234_5678, 1'b1, '{ST_NOTFOUND, 32'h0000_0000, 5'd0}},
      '{OP_POP,  32'hFFFF_FFFF, 1'b1, '{ST_OK,       32'h8000_0000, 5'd0}},
      '{OP_NONE, 32'h0000_0000, 1'b1, '{ST_OK,       32'h0000_0000, 5'd0}}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      send_item(dir_tab[i].op, dir_tab[i].value, dir_tab[i].typed, dir_tab[i].res);
    end

    // random part: phases that lean towards filling, draining or neither
    rand_done = 0;
    mode      = 0;
    mode_left = 0;
    while (rand_done < NUM_RAND) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 40);
      end
      mode_left--;
      no_idle  = (rand_done >= 150 && rand_done < 260);
      push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      roll     = $urandom_range(0, 99);
      if (roll < 3) begin
        op = OP_NONE;
      end else if (roll < 25) begin
        op = OP_SRCH;
      end else begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      end
      case (op)
        OP_SRCH: v = (depth_used > 0 && $urandom_range(0, 2) != 0) ?
                     stack_img[$urandom_range(0, depth_used - 1)] : pick_value();
        OP_PUSH: v = pick_value();
        default: v = $urandom;
      endcase
      send_item(op, v, 1'b0, '{ST_OK, '0, '0});
      if (op != OP_NONE) rand_done++;
    end

    start     <= 1'b0;
    in_opcode <= OP_NONE;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (STACK_DEPTH + 4) @(posedge clk);

    $display("items: %0d push (%0d overflow), %0d pop (%0d underflow), %0d unused opcode",
             n_push, n_over, n_pop, n_under, n_none);
    $display("searches: %0d (%0d hit, %0d miss, %0d hit near the bottom of a full stack)",
             n_srch, n_found, n_miss, n_deep);
    if (errors == 0) begin
      $display("PASS lifo_stack_with_search");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL lifo_stack_with_search");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAIL lifo_stack_with_search");
    $finish;
  end

endmodule

@@ lifo_stack_with_search.f @@
hdl/lstk_pkg.sv
hdl/lstk_ctrl.sv
hdl/lstk_dpath.sv
hdl/lifo_stack_with_search.sv
test/lifo_stack_with_search_tb.sv
